// File: sv/nand_hamming_ecc_engine_core_defines.svh
// Assertion macros for the NAND Hamming ECC engine.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef NAND_HAMMING_ECC_ENGINE_CORE_DEFINES_SVH
`define NAND_HAMMING_ECC_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NHE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nhe assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nhe assertion failed");

`endif

// File: sv/nhe_pkg.sv
// Shared types, constants and parity functions of the NAND Hamming ECC engine.
// Has no dependencies; used by nhe_ecc_eval and the top level.
`default_nettype none

package nhe_pkg;

  // Bytes in one chunk and the width of the running byte count.
  localparam int CHUNK_BYTES = 256;
  localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
  localparam int IDX_W = 8;
  localparam int ECC_W = 24;

  // Outcome codes reported with each ECC.
  typedef enum logic [2:0] {
    ST_CLEAN  = 3'd0,
    ST_DATA   = 3'd1,
    ST_ECC    = 3'd2,
    ST_UNCORR = 3'd3,
    ST_GEN    = 3'd4
  } status_t;

  // Running parity accumulators of one chunk.
  typedef struct packed {
    logic [7:0] column;
    logic [7:0] line;
    logic [7:0] line_prime;
  } acc_t;

  // One result item.
  typedef struct packed {
    logic [ECC_W-1:0] ecc;
    status_t          status;
    logic [7:0]       err_byte;
    logic [2:0]       err_bit;
  } res_t;

  // Column parity bits of one byte: P4 P4' P2 P2' P1 P1' 0 odd-parity.
  function automatic logic [7:0] column_bits(input logic [7:0] v);
    logic [7:0] r;
    r[0] = ^v;
    r[1] = 1'b0;
    r[2] = ^(v & 8'h55);
    r[3] = ^(v & 8'hAA);
    r[4] = ^(v & 8'h33);
    r[5] = ^(v & 8'hCC);
    r[6] = ^v[3:0];
    r[7] = ^v[7:4];
    return r;
  endfunction

  // Interleave two nibbles: hi bit k goes to 2k+1, lo bit k to 2k.
  function automatic logic [7:0] interleave(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] r;
    for (int k = 0; k < 4; k++) begin
      r[2*k+1] = hi[k];
      r[2*k]   = lo[k];
    end
    return r;
  endfunction

  // True when exactly one bit of the syndrome is set.
  function automatic logic single_bit(input logic [ECC_W-1:0] x);
    return (x != '0) && ((x & (x - ECC_W'(1))) == '0);
  endfunction

endpackage

`default_nettype wire

// File: sv/nhe_ecc_eval.sv
// ECC formatting and syndrome classification for one finished chunk.
// Depends on nhe_pkg for the accumulator and result types and helper functions.
`default_nettype none

module nhe_ecc_eval (
  input  wire nhe_pkg::acc_t               acc,
  input  wire logic [nhe_pkg::ECC_W-1:0]   stored_ecc,
  input  wire logic                        check,
  input  wire logic [nhe_pkg::CNT_W-1:0]   count,
  output nhe_pkg::res_t                    res
);

  logic [7:0] e0, e1, e2;
  logic [7:0] d0, d1, d2;
  logic [7:0] loc_byte;
  logic [2:0] loc_bit;
  logic       correctable;

  // Parity bits are stored inverted; the two low bits of byte2 are always one.
  assign e0 = ~nhe_pkg::interleave(acc.line[3:0], acc.line_prime[3:0]);
  assign e1 = ~nhe_pkg::interleave(acc.line[7:4], acc.line_prime[7:4]);
  assign e2 = ~acc.column | 8'h03;

  // Syndrome against the stored ECC.
  assign d0 = stored_ecc[7:0] ^ e0;
  assign d1 = stored_ecc[15:8] ^ e1;
  assign d2 = stored_ecc[23:16] ^ e2;

  // A single data-bit flip makes every parity pair differ in exactly one bit.
  assign correctable = (((d0 ^ (d0 >> 1)) & 8'h55) == 8'h55) &&
                       (((d1 ^ (d1 >> 1)) & 8'h55) == 8'h55) &&
                       (((d2 ^ (d2 >> 1)) & 8'h54) == 8'h54);

  assign loc_byte = {d1[7], d1[5], d1[3], d1[1], d0[7], d0[5], d0[3], d0[1]};
  assign loc_bit  = {d2[7], d2[5], d2[3]};

  // Classify the outcome.
  always_comb begin
    res.ecc      = {e2, e1, e0};
    res.status   = nhe_pkg::ST_GEN;
    res.err_byte = '0;
    res.err_bit  = '0;
    if (check) begin
      if ({d2, d1, d0} == '0) begin
        res.status = nhe_pkg::ST_CLEAN;
      end else if (correctable) begin
        if ({1'b0, loc_byte} >= count) begin
          res.status = nhe_pkg::ST_UNCORR;
        end else begin
          res.status   = nhe_pkg::ST_DATA;
          res.err_byte = loc_byte;
          res.err_bit  = loc_bit;
        end
      end else if (nhe_pkg::single_bit({d2, d1, d0})) begin
        res.status = nhe_pkg::ST_ECC;
      end else begin
        res.status = nhe_pkg::ST_UNCORR;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/nand_hamming_ecc_engine_core.sv
// Top level of the NAND Hamming ECC engine (256-byte chunk, 3-byte ECC).
// Depends on nhe_pkg, nhe_ecc_eval and nand_hamming_ecc_engine_core_defines.svh.
//
//   Channel  Dir  tdata fields (low bit up)                          tlast
//   s_*      in   data_byte[7:0] check[8] stored_ecc[32:9] pad       last
//   m_*      out  computed_ecc[23:0] status[26:24] err_byte[34:27]   -
//                 err_bit[37:35] pad
//
// One byte is taken per cycle unless a final byte waits for the result slot. The input
// register takes the byte that ends a chunk, and the result register loads its ECC from there
// once the slot is free; m_tvalid is driven by the result register.
// Synchronous reset clears the accumulators, byte count and both valid flags.
// A stalled result holds the output register; one more byte is still taken into the
// input register, and bytes that end no chunk keep flowing past the stall.
`default_nettype none
`include "nand_hamming_ecc_engine_core_defines.svh"

module nand_hamming_ecc_engine_core (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [39:0] s_tdata,   // data_byte, check, stored_ecc, zero pad
  input  wire  logic        s_tlast,
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic       [39:0] m_tdata    // computed_ecc, status, err_byte, err_bit, zero pad
);

  // Input register.
  logic                         v1;
  logic [7:0]                   d1_byte;
  logic                         d1_last;
  logic                         d1_check;
  logic [nhe_pkg::ECC_W-1:0]    d1_stored;

  // Chunk state.
  nhe_pkg::acc_t                acc;
  nhe_pkg::acc_t                acc_next;
  logic [nhe_pkg::CNT_W-1:0]    byte_count;
  logic [nhe_pkg::CNT_W-1:0]    count_next;

  // Result register.
  logic                         ov;
  nhe_pkg::res_t                out_res;
  nhe_pkg::res_t                eval_res;

  logic [7:0]                   cb;
  logic [nhe_pkg::IDX_W-1:0]    idx;
  logic                         ends;
  logic                         out_free;
  logic                         adv;

  // Handshake: a byte that ends no chunk always moves on; a final byte needs a free slot.
  assign out_free = !ov || m_tready;
  assign adv      = v1 && (!ends || out_free);
  assign s_tready = !v1 || adv;

  // Accumulator update for the byte in the input register.
  assign idx        = byte_count[nhe_pkg::IDX_W-1:0];
  assign cb         = nhe_pkg::column_bits(d1_byte);
  assign count_next = byte_count + nhe_pkg::CNT_W'(1);
  assign ends       = d1_last || (count_next == nhe_pkg::CNT_W'(nhe_pkg::CHUNK_BYTES));

  always_comb begin
    acc_next.column     = acc.column ^ cb;
    acc_next.line       = acc.line;
    acc_next.line_prime = acc.line_prime;
    if (cb[0]) begin
      acc_next.line       = acc.line ^ idx;
      acc_next.line_prime = acc.line_prime ^ ~idx;
    end
  end

  nhe_ecc_eval u_eval (
    .acc        (acc_next),
    .stored_ecc (d1_stored),
    .check      (d1_check),
    .count      (count_next),
    .res        (eval_res)
  );

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      d1_byte   <= s_tdata[7:0];
      d1_check  <= s_tdata[8];
      d1_stored <= s_tdata[32:9];
      d1_last   <= s_tlast;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  // Accumulators and byte count; a finished chunk starts over from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      byte_count <= '0;
    end else if (adv) begin
      if (ends) begin
        acc        <= '0;
        byte_count <= '0;
      end else begin
        acc        <= acc_next;
        byte_count <= count_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv && ends) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv && ends) begin
      out_res <= eval_res;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {2'b00, out_res.err_bit, out_res.err_byte, out_res.status, out_res.ecc};

  // A finished chunk leaves all state cleared for the next one.
  `NHE_ASSERT_NEXT(a_chunk_clear, adv && ends, byte_count == '0 && acc == '0)

  // The byte count never reaches the chunk size between transactions.
  `NHE_ASSERT_NOW(a_count_range, 1'b1, byte_count < nhe_pkg::CNT_W'(nhe_pkg::CHUNK_BYTES))

  // A location is reported only with a correctable data bit.
  `NHE_ASSERT_NOW(a_loc_only_data, ov && out_res.status != nhe_pkg::ST_DATA,
                  out_res.err_byte == '0 && out_res.err_bit == '0)

  // The two fixed bits of the third ECC byte are always set.
  `NHE_ASSERT_NOW(a_fixed_bits, ov, out_res.ecc[17:16] == 2'b11)

endmodule

`default_nettype wire

// File: verif/tb_nand_hamming_ecc_engine_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for nand_hamming_ecc_engine_core, the 256-byte / 3-byte NAND Hamming
// ECC engine. Depends on nhe_pkg and the RTL; every ECC report is predicted inside the bench.
module tb_nand_hamming_ecc_engine_core;

  localparam int CHUNK_LEN = nhe_pkg::CHUNK_BYTES;

  typedef logic [7:0] byte_q_t[$];

  // Running parities of the chunk under way, plus the number of bytes taken.
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] line;
    logic [7:0] line_p;
    logic [8:0] count;
  } parity_acc_t;

  // One expected ECC report.
  typedef struct packed {
    logic [23:0]      ecc;
    nhe_pkg::status_t status;
    logic [7:0]       err_byte;
    logic [2:0]       err_bit;
  } ecc_report_t;

  // How the stored ECC sent with the final byte of a chunk is made up.
  typedef enum int {
    STORE_NONE,
    STORE_CLEAN,
    STORE_DATA_FLIP,
    STORE_FLIP_BEYOND,
    STORE_ECC_FLIP,
    STORE_DOUBLE_FLIP,
    STORE_NOISE
  } stored_kind_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_byte[7:0], check[8], stored_ecc[32:9], zero pad
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // computed_ecc[23:0], status[26:24], err_byte[34:27], err_bit[37:35]

  ecc_report_t pending_reports[$];
  parity_acc_t chunk_acc = '0;
  int          report_errors = 0;
  int          bytes_sent = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  nand_hamming_ecc_engine_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Column parity of one byte, MSB down: P4 P4' P2 P2' P1 P1' 0 odd-parity.
  function automatic logic [7:0] column_parity(input logic [7:0] d);
    return {^d[7:4], ^d[3:0], ^(d & 8'hCC), ^(d & 8'h33),
            ^(d & 8'hAA), ^(d & 8'h55), 1'b0, ^d};
  endfunction

  // Folds one byte into the running parities; the byte's position is the count so far.
  function automatic parity_acc_t absorb_byte(input parity_acc_t a, input logic [7:0] d);
    logic [7:0] cp;
    logic [7:0] idx;
    cp = column_parity(d);
    idx = a.count[7:0];
    a.col = a.col ^ cp;
    if (cp[0]) begin
      a.line = a.line ^ idx;
      a.line_p = a.line_p ^ ~idx;
    end
    a.count = a.count + 9'd1;
    return a;
  endfunction

  // Builds the inverted 3-byte ECC: line parity pairs in bytes 0 and 1, column in byte 2.
  function automatic logic [23:0] ecc_from_acc(input parity_acc_t a);
    logic [23:0] e;
    for (int k = 0; k < 4; k++) begin
      e[2*k+1]   = ~a.line[k];
      e[2*k]     = ~a.line_p[k];
      e[8+2*k+1] = ~a.line[4+k];
      e[8+2*k]   = ~a.line_p[4+k];
    end
    e[23:16] = ~a.col | 8'h03;
    return e;
  endfunction

  // Report for a finished chunk: ECC plus the classification of its difference to the stored one.
  function automatic ecc_report_t classify_ecc(input parity_acc_t a, input logic check,
                                               input logic [23:0] stored);
    ecc_report_t r;
    logic [23:0] diff;
    logic        pairs_split;
    logic [7:0]  loc_byte;
    logic [2:0]  loc_bit;
    r.ecc = ecc_from_acc(a);
    r.status = nhe_pkg::ST_GEN;
    r.err_byte = '0;
    r.err_bit = '0;
    if (!check) return r;
    diff = stored ^ r.ecc;
    // A single data-bit error flips exactly one bit of every parity pair.
    pairs_split = 1'b1;
    for (int k = 0; k < 8; k++) pairs_split &= diff[2*k] ^ diff[2*k+1];
    for (int k = 9; k < 12; k++) pairs_split &= diff[2*k] ^ diff[2*k+1];
    for (int k = 0; k < 8; k++) loc_byte[k] = diff[2*k+1];
    for (int k = 0; k < 3; k++) loc_bit[k] = diff[2*(9+k)+1];
    if (diff == '0) begin
      r.status = nhe_pkg::ST_CLEAN;
    end else if (pairs_split) begin
      // A located byte that never arrived cannot be repaired.
      if ({1'b0, loc_byte} >= a.count) begin
        r.status = nhe_pkg::ST_UNCORR;
      end else begin
        r.status = nhe_pkg::ST_DATA;
        r.err_byte = loc_byte;
        r.err_bit = loc_bit;
      end
    end else if ($countones(diff) == 1) begin
      r.status = nhe_pkg::ST_ECC;
    end else begin
      r.status = nhe_pkg::ST_UNCORR;
    end
    return r;
  endfunction

  // ECC of a chunk with one optional bit flipped; a flip past the end pads with zero bytes.
  function automatic logic [23:0] chunk_ecc(input byte_q_t bytes, input int flip_at,
                                            input int flip_bit);
    parity_acc_t a;
    logic [7:0]  d;
    int          span;
    a = '0;
    span = (flip_at >= bytes.size()) ? flip_at + 1 : bytes.size();
    for (int i = 0; i < span; i++) begin
      d = (i < bytes.size()) ? bytes[i] : 8'h00;
      if (i == flip_at) d[flip_bit] = ~d[flip_bit];
      a = absorb_byte(a, d);
    end
    return ecc_from_acc(a);
  endfunction

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    int      sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      q.push_back(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom));
    end
    return q;
  endfunction

  // Sends one byte transaction with random source gaps, then updates the prediction.
  task automatic send_byte(input logic [7:0] d, input logic end_mark, input logic check,
                           input logic [23:0] stored);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, 8'($urandom)};
      s_tlast <= 1'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, stored, check, d};
    s_tlast <= end_mark;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chunk_acc = absorb_byte(chunk_acc, d);
    if (end_mark || chunk_acc.count == CHUNK_LEN) begin
      pending_reports.push_back(classify_ecc(chunk_acc, check, stored));
      chunk_acc = '0;
    end
    bytes_sent++;
  endtask

  // Sends a whole chunk. For data flips loc_a/loc_b are byte and bit, for an ECC flip loc_a
  // is the ECC bit, for noise loc_a is a fixed stored value or negative for a random one.
  task automatic send_chunk(input byte_q_t bytes, input stored_kind_t kind,
                            input logic end_mark, input int loc_a, input int loc_b);
    logic [23:0] good_ecc;
    logic [23:0] stored;
    logic        check;
    int          n;
    n = bytes.size();
    good_ecc = chunk_ecc(bytes, -1, 0);
    check = (kind != STORE_NONE);
    case (kind)
      STORE_NONE: stored = 24'($urandom);
      STORE_NOISE: stored = (loc_a < 0) ? 24'($urandom) : 24'(loc_a);
      STORE_CLEAN: stored = good_ecc;
      STORE_DATA_FLIP, STORE_FLIP_BEYOND: stored = chunk_ecc(bytes, loc_a, loc_b);
      STORE_ECC_FLIP: stored = good_ecc ^ (24'd1 << loc_a);
      default: begin
        // The ECC is affine in the data, so two flips combine by XOR.
        stored = chunk_ecc(bytes, loc_a, loc_b) ^ good_ecc ^
                 chunk_ecc(bytes, $urandom_range(n - 1), $urandom_range(7));
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_byte(bytes[i], end_mark, check, stored);
      else send_byte(bytes[i], 1'b0, 1'($urandom), 24'($urandom));
    end
  endtask

  // Extremes, every outcome and the boundary cases of the error locator.
  task automatic test_directed_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_chunk('{8'h00}, STORE_NONE, 1'b1, 0, 0);
    send_chunk('{8'hFF}, STORE_CLEAN, 1'b1, 0, 0);
    send_chunk('{8'h01}, STORE_DATA_FLIP, 1'b1, 0, 7);
    send_chunk('{8'h80, 8'h7F}, STORE_ECC_FLIP, 1'b1, 23, 0);
    send_chunk('{8'hA5, 8'h5A}, STORE_ECC_FLIP, 1'b1, 0, 0);
    send_chunk('{8'h00, 8'hFF, 8'h3C}, STORE_DATA_FLIP, 1'b1, 2, 0);
    // Located bit far past the data, then exactly one byte past it.
    send_chunk('{8'h00, 8'h00, 8'h00}, STORE_FLIP_BEYOND, 1'b1, 255, 7);
    send_chunk('{8'hC3, 8'h96}, STORE_FLIP_BEYOND, 1'b1, 2, 0);
    send_chunk('{8'h11, 8'h22, 8'h44, 8'h88}, STORE_DOUBLE_FLIP, 1'b1, 0, 3);
    send_chunk('{8'hFF}, STORE_NOISE, 1'b1, 24'hFFFFFF, 0);
    send_chunk('{8'h00}, STORE_NOISE, 1'b1, 0, 0);
  endtask

  // Full chunks: one closed by the byte count alone, one with the flag on the last byte.
  task automatic test_full_chunk();
    src_idle_pct = 23;
    sink_stall_pct = 23;
    send_chunk(random_bytes(CHUNK_LEN), STORE_DATA_FLIP, 1'b0, CHUNK_LEN - 1, 7);
    send_chunk(random_bytes(CHUNK_LEN), STORE_ECC_FLIP, 1'b1, 17, 0);
  endtask

  // Random chunks, mostly short, with every kind of stored ECC.
  task automatic test_random_chunks(input int src_pct, input int sink_pct, input int budget);
    byte_q_t      bytes;
    stored_kind_t kind;
    int           n;
    int           sel;
    int           start;
    int           loc_a;
    int           loc_b;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      sel = $urandom_range(99);
      n = (sel < 60) ? $urandom_range(6, 1) :
          (sel < 95) ? $urandom_range(24, 7) : $urandom_range(255, 25);
      bytes = random_bytes(n);
      sel = $urandom_range(99);
      loc_a = $urandom_range(n - 1);
      loc_b = $urandom_range(7);
      if (sel < 15) begin
        kind = STORE_NONE;
      end else if (sel < 30) begin
        kind = STORE_CLEAN;
      end else if (sel < 55) begin
        kind = STORE_DATA_FLIP;
      end else if (sel < 65) begin
        kind = STORE_FLIP_BEYOND;
        loc_a = $urandom_range(255, n);
      end else if (sel < 80) begin
        kind = STORE_ECC_FLIP;
        loc_a = $urandom_range(23);
      end else if (sel < 90) begin
        kind = STORE_DOUBLE_FLIP;
      end else begin
        kind = STORE_NOISE;
        loc_a = -1;
      end
      send_chunk(bytes, kind, 1'b1, loc_a, loc_b);
    end
  endtask

  // Result side: random back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compares each accepted ECC report with the oldest prediction.
  always @(posedge clk) begin
    ecc_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected ECC report, m_tdata = %h", m_tdata);
        report_errors++;
      end else begin
        want = pending_reports.pop_front();
        if (m_tdata[23:0] !== want.ecc) begin
          $error("computed_ecc: expected %h, got %h", want.ecc, m_tdata[23:0]);
          report_errors++;
        end
        if (m_tdata[26:24] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[26:24]);
          report_errors++;
        end
        if (m_tdata[34:27] !== want.err_byte) begin
          $error("err_byte: expected %0d, got %0d", want.err_byte, m_tdata[34:27]);
          report_errors++;
        end
        if (m_tdata[37:35] !== want.err_bit) begin
          $error("err_bit: expected %0d, got %0d", want.err_bit, m_tdata[37:35]);
          report_errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_chunk();
    test_random_chunks(0, 0, 125);
    test_random_chunks(60, 0, 125);
    test_random_chunks(0, 60, 125);
    test_random_chunks(23, 23, 125);

    // Let the last reports drain, then watch a little longer for stray ones.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (report_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
